// ===== hw/rtl/ima_adpcm_codec_defines.svh =====
// Assertion macros shared by the IMA ADPCM codec checker.
// Included by hw/rtl/ima_chk.sv; depends on nothing else.
`ifndef IMA_ADPCM_CODEC_DEFINES_SVH
`define IMA_ADPCM_CODEC_DEFINES_SVH

// Clocked assertion that is switched off while reset is held.
`define IMA_ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ima_adpcm_codec: assertion failed");

// Clocked assertion that also holds across reset.
`define IMA_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("ima_adpcm_codec: assertion failed");

`endif

// ===== hw/rtl/ima_pkg.sv =====
// Shared types, constants and tables of the IMA ADPCM codec.
// Used by ima_front, ima_back and the top level; depends on nothing.
`default_nettype none

package ima_pkg;

    localparam int STEP_TABLE_DEPTH = 89;
    localparam int INDEX_W          = $clog2(STEP_TABLE_DEPTH);
    localparam int STEP_W           = 15;
    localparam int SAMPLE_W         = 16;
    localparam int QUEUE_DEPTH      = 2;
    localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

    localparam logic [INDEX_W-1:0]         INDEX_MAX  = INDEX_W'(STEP_TABLE_DEPTH - 1);
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sd32768;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sd32767;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    localparam logic [STEP_W-1:0] STEP_TABLE [STEP_TABLE_DEPTH] = '{
        15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14,
        15'd16, 15'd17, 15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31,
        15'd34, 15'd37, 15'd41, 15'd45, 15'd50, 15'd55, 15'd60, 15'd66,
        15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118, 15'd130, 15'd143,
        15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279, 15'd307,
        15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
        15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282,
        15'd1411, 15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499,
        15'd2749, 15'd3024, 15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871,
        15'd5358, 15'd5894, 15'd6484, 15'd7132, 15'd7845, 15'd8630, 15'd9493,
        15'd10442, 15'd11487, 15'd12635, 15'd13899, 15'd15289, 15'd16818,
        15'd18500, 15'd20350, 15'd22385, 15'd24623, 15'd27086, 15'd29794,
        15'd32767
    };

    localparam logic signed [4:0] INDEX_MOVES [8] = '{
        -5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd2, 5'sd4, 5'sd6, 5'sd8
    };

    // One queued item, tagged with the mode that was current when it arrived.
    typedef struct packed {
        logic                       mode;
        logic                       final_item;
        logic signed [SAMPLE_W-1:0] data;
    } item_t;

    // Head of the queue as seen by the back end.
    typedef struct packed {
        logic  valid;
        item_t item;
    } q_head_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_QUANT,
        BK_ENC_APPLY,
        BK_DEC_LO,
        BK_DEC_HI
    } back_state_t;

    function automatic logic [STEP_W-1:0] step_lookup(input logic [INDEX_W-1:0] idx);
        return STEP_TABLE[idx];
    endfunction

    function automatic logic signed [4:0] index_move(input logic [2:0] mag);
        return INDEX_MOVES[mag];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ima_front.sv =====
// Front end of the IMA ADPCM codec: mode register, input handshake and
// a two-entry item queue toward the back end. Depends on ima_pkg.
`default_nettype none

module ima_front (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic                                cfg_codec_mode,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic signed [ima_pkg::SAMPLE_W-1:0] s_data_in,
    input  wire logic                                s_final_item,
    output ima_pkg::q_head_t                         head,
    input  wire logic                                head_pop
);
    import ima_pkg::*;

    logic              mode_reg;
    item_t             q_mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push;
    logic              pop;

    assign cfg_ready = 1'b1;
    assign s_ready   = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push      = s_valid && s_ready;
    assign pop       = head_pop && (count_reg != '0);

    assign head = '{valid: (count_reg != '0), item: q_mem_reg[rd_ptr_reg]};

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_ENCODE;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                mode_reg <= cfg_codec_mode;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Each item is tagged with the mode at acceptance.
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= '{mode: mode_reg, final_item: s_final_item,
                                       data: s_data_in};
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ima_back.sv =====
// Back end of the IMA ADPCM codec: quantizer, nibble update unit, nibble
// packing and the output register. Depends on ima_pkg.
`default_nettype none

module ima_back (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire ima_pkg::q_head_t                    head,
    output logic                                     head_pop,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [ima_pkg::SAMPLE_W-1:0]      m_data_out,
    output logic                                     m_run_end
);
    import ima_pkg::*;

    back_state_t                state_reg, state_next;
    item_t                      item_reg;
    logic [3:0]                 code_reg;
    logic signed [SAMPLE_W-1:0] pred_reg;
    logic [INDEX_W-1:0]         index_reg;
    logic [3:0]                 held_reg;
    logic                       pending_reg;
    logic                       m_valid_reg;
    logic signed [SAMPLE_W-1:0] m_data_out_reg;
    logic                       m_run_end_reg;

    logic                       out_free;
    logic                       enc_emit;
    logic                       step_fire;
    logic                       step_last;
    logic                       emit;
    logic signed [SAMPLE_W-1:0] emit_data;
    logic                       emit_run_end;

    // Quantizer signals.
    logic signed [SAMPLE_W:0]   diff;
    logic [SAMPLE_W-1:0]        mag0, mag1, mag2;
    logic [SAMPLE_W-1:0]        qstep;
    logic [3:0]                 quant_code;

    // Update unit signals.
    logic [3:0]                 apply_code;
    logic [STEP_W-1:0]          step_cur;
    logic [STEP_W+1:0]          vpdiff;
    logic signed [SAMPLE_W+1:0] pred_sum;
    logic signed [SAMPLE_W-1:0] pred_new;
    logic signed [INDEX_W+1:0]  index_sum;
    logic signed [4:0]          move;
    logic [INDEX_W-1:0]         index_new;

    assign out_free   = !m_valid_reg || m_ready;
    assign enc_emit   = pending_reg || item_reg.final_item;
    assign m_valid    = m_valid_reg;
    assign m_data_out = m_data_out_reg;
    assign m_run_end  = m_run_end_reg;

    // Quantize the sample against the predictor, one sign and three magnitude bits.
    always_comb begin
        diff          = {item_reg.data[SAMPLE_W-1], item_reg.data}
                      - {pred_reg[SAMPLE_W-1], pred_reg};
        mag0          = diff[SAMPLE_W] ? SAMPLE_W'(-diff) : diff[SAMPLE_W-1:0];
        qstep         = {1'b0, step_cur};
        quant_code[3] = diff[SAMPLE_W];
        quant_code[2] = (mag0 >= qstep);
        mag1          = quant_code[2] ? mag0 - qstep : mag0;
        quant_code[1] = (mag1 >= (qstep >> 1));
        mag2          = quant_code[1] ? mag1 - (qstep >> 1) : mag1;
        quant_code[0] = (mag2 >= (qstep >> 2));
    end

    // Nibble update shared by encode and decode.
    always_comb begin
        case (state_reg)
            BK_DEC_LO: apply_code = item_reg.data[3:0];
            BK_DEC_HI: apply_code = item_reg.data[7:4];
            default:   apply_code = code_reg;
        endcase
        step_cur = step_lookup(index_reg);
        vpdiff   = {2'b00, step_cur >> 3}
                 + (apply_code[2] ? {2'b00, step_cur} : '0)
                 + (apply_code[1] ? {2'b00, step_cur >> 1} : '0)
                 + (apply_code[0] ? {2'b00, step_cur >> 2} : '0);
        if (apply_code[3]) begin
            pred_sum = {{2{pred_reg[SAMPLE_W-1]}}, pred_reg} - $signed({1'b0, vpdiff});
        end else begin
            pred_sum = {{2{pred_reg[SAMPLE_W-1]}}, pred_reg} + $signed({1'b0, vpdiff});
        end
        if (pred_sum < $signed({{2{SAMPLE_MIN[SAMPLE_W-1]}}, SAMPLE_MIN})) begin
            pred_new = SAMPLE_MIN;
        end else if (pred_sum > $signed({2'b00, SAMPLE_MAX})) begin
            pred_new = SAMPLE_MAX;
        end else begin
            pred_new = pred_sum[SAMPLE_W-1:0];
        end
        move      = index_move(apply_code[2:0]);
        index_sum = $signed({2'b00, index_reg}) + {{(INDEX_W-3){move[4]}}, move};
        if (index_sum < 0) begin
            index_new = '0;
        end else if (index_sum > $signed({2'b00, INDEX_MAX})) begin
            index_new = INDEX_MAX;
        end else begin
            index_new = index_sum[INDEX_W-1:0];
        end
    end

    // Step control: which steps may complete and what they emit.
    always_comb begin
        step_fire    = 1'b0;
        step_last    = 1'b0;
        emit         = 1'b0;
        emit_data    = pred_new;
        emit_run_end = 1'b1;
        case (state_reg)
            BK_IDLE: begin
                step_last = 1'b1;
            end
            BK_QUANT: begin
                step_fire = 1'b1;
            end
            BK_ENC_APPLY: begin
                step_fire = !enc_emit || out_free;
                step_last = step_fire;
                emit      = enc_emit && out_free;
                // A lone flushed nibble sits in the low half with a zero upper half.
                emit_data = pending_reg ? {8'h00, code_reg, held_reg} : {12'h000, code_reg};
            end
            BK_DEC_LO: begin
                step_fire    = out_free;
                emit         = out_free;
                emit_run_end = 1'b0;
            end
            BK_DEC_HI: begin
                step_fire = out_free;
                step_last = out_free;
                emit      = out_free;
            end
            default: begin
                step_last = 1'b1;
            end
        endcase
        head_pop = step_last && head.valid;
    end

    always_comb begin
        case (state_reg)
            BK_QUANT:  state_next = BK_ENC_APPLY;
            BK_DEC_LO: state_next = step_fire ? BK_DEC_HI : BK_DEC_LO;
            default:   state_next = state_reg;
        endcase
        if (step_last) begin
            if (head.valid) begin
                state_next = (head.item.mode == MODE_DECODE) ? BK_DEC_LO : BK_QUANT;
            end else begin
                state_next = BK_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            pred_reg    <= '0;
            index_reg   <= '0;
            held_reg    <= '0;
            pending_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (step_fire && (state_reg != BK_QUANT)) begin
                pred_reg  <= pred_new;
                index_reg <= index_new;
            end
            if (step_fire && (state_reg == BK_ENC_APPLY)) begin
                if (enc_emit) begin
                    held_reg    <= 4'h0;
                    pending_reg <= 1'b0;
                end else begin
                    held_reg    <= code_reg;
                    pending_reg <= 1'b1;
                end
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (head_pop) begin
            item_reg <= head.item;
        end
        if (state_reg == BK_QUANT) begin
            code_reg <= quant_code;
        end
        if (emit) begin
            m_data_out_reg <= emit_data;
            m_run_end_reg  <= emit_run_end;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ima_adpcm_codec.sv =====
// Top level of the IMA ADPCM 4-bit codec: front end and back end joined by
// the item queue. Depends on ima_pkg, ima_front and ima_back.
//
//   Channel   Direction  Handshake            Payload
//   cfg       in         cfg_valid/cfg_ready  cfg_codec_mode
//   s         in         s_valid/s_ready      s_data_in, s_final_item
//   m         out        m_valid/m_ready      m_data_out, m_run_end
//
// Every item occupies the back end for two steps in either mode: encode quantizes
// and then updates the predictor, decode runs the shared nibble update unit once
// per nibble. The next item is popped only as the current one's last step completes.
// Reset is synchronous and active low; it clears the mode, predictor, step
// index, pending half byte, queue and output valid flag. There is no clearing pass.
// A full output register holds the back end; the two-entry queue keeps the
// input side accepting items until it fills.
`default_nettype none

module ima_adpcm_codec (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic                                cfg_codec_mode,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic signed [ima_pkg::SAMPLE_W-1:0] s_data_in,
    input  wire logic                                s_final_item,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [ima_pkg::SAMPLE_W-1:0]      m_data_out,
    output logic                                     m_run_end
);
    import ima_pkg::*;

    // The queue head carries each item with the mode it was accepted under,
    // so a later mode write never changes an item already in flight.
    q_head_t head;
    logic    head_pop;

    ima_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_codec_mode (cfg_codec_mode),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_in      (s_data_in),
        .s_final_item   (s_final_item),
        .head           (head),
        .head_pop       (head_pop)
    );

    // The back end keeps predictor, step index and the half byte waiting for
    // its partner; all persist across mode changes, the first two also across blocks.
    ima_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .head_pop   (head_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data_out (m_data_out),
        .m_run_end  (m_run_end)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/ima_chk.sv =====
// Port-level checker for the IMA ADPCM codec and its bind to the top level.
// Depends on ima_adpcm_codec_defines.svh and ima_adpcm_codec.
`default_nettype none
`include "ima_adpcm_codec_defines.svh"

module ima_chk (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        cfg_ready,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [15:0] m_data_out,
    input wire logic        m_run_end
);

    `IMA_ASSERT_CLK(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid)
    `IMA_ASSERT_CLK(a_out_stable, aclk, aresetn, m_valid && !m_ready |=> $stable(m_data_out) && $stable(m_run_end))
    `IMA_ASSERT_NR(a_reset_out, aclk, !aresetn |=> !m_valid)
    `IMA_ASSERT_NR(a_reset_in, aclk, !aresetn |=> s_ready && cfg_ready)

endmodule

bind ima_adpcm_codec ima_chk u_ima_chk (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .cfg_ready  (cfg_ready),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_data_out (m_data_out),
    .m_run_end  (m_run_end)
);

`default_nettype wire
